// ===== src/lpr_pkg.sv =====
package lpr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 1;
    localparam int ERR_SUM_BITS  = COORD_BITS + 3;
    localparam int STEPS_BITS    = COORD_BITS + 1;
    localparam int CLIP_BITS     = 11;
    localparam int ROWB_BITS     = 8;
    localparam int IL_BITS       = 2;
    localparam int OFFS_BITS     = 16;
    localparam int MASK_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = CLIP_BITS;
    localparam int CMP_BITS      = (COORD_BITS > CLIP_BITS ? COORD_BITS : CLIP_BITS) + 1;

    localparam int unsigned BANK_STRIDE = 32'h2000;
    localparam int BANK_SHIFT  = $clog2(BANK_STRIDE);
    localparam int COL_SHIFT   = 3;
    localparam logic [MASK_BITS-1:0] MASK_TOP = 8'h80;

    localparam logic [CLIP_BITS-1:0] CLIP_MIN_X_RST = 11'd0;
    localparam logic [CLIP_BITS-1:0] CLIP_MAX_X_RST = 11'd599;
    localparam logic [CLIP_BITS-1:0] CLIP_MIN_Y_RST = 11'd0;
    localparam logic [CLIP_BITS-1:0] CLIP_MAX_Y_RST = 11'd799;
    localparam logic [ROWB_BITS-1:0] ROW_BYTES_RST  = 8'd100;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLIP_MIN_X,
        REG_CLIP_MAX_X,
        REG_CLIP_MIN_Y,
        REG_CLIP_MAX_Y,
        REG_ROW_BYTES,
        REG_INTERLEAVE
    } reg_idx_t;

    typedef enum logic [IL_BITS-1:0] {
        IL_FOUR_WAY,
        IL_LINEAR,
        IL_TWO_WAY
    } interleave_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_XOR
    } op_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [1:0]                   draw_op;
    } in_item_t;

    typedef struct packed {
        logic                 write_valid;
        logic [OFFS_BITS-1:0] byte_offset;
        logic [MASK_BITS-1:0] bit_mask;
        logic [1:0]           op_out;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic [CLIP_BITS-1:0] clip_min_x;
        logic [CLIP_BITS-1:0] clip_max_x;
        logic [CLIP_BITS-1:0] clip_min_y;
        logic [CLIP_BITS-1:0] clip_max_y;
        logic [ROWB_BITS-1:0] row_bytes;
        interleave_t          interleave;
    } cfg_t;

    typedef struct packed {
        logic                         active;
        logic                         last;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        op_t                          op;
    } pixel_t;

endpackage

// ===== src/line_pixel_rasterizer.sv =====
// channel   ports                           moves
// s_        s_valid s_ready s_data          load or step transaction in
// m_        m_valid m_ready m_data          one pixel write per active step
// cfg_      cfg_wr_en cfg_addr cfg_wdata    register write, no handshake
//
// one transaction per cycle when not stalled; a step's pixel is on m_ the next cycle
// the error update and the offset multiply-add are both combinational
// loads and idle steps are taken without producing a pixel
// s_ready drops only while the output register is full and m_ready is low
// reset (aresetn, synchronous) leaves the walker idle and registers at their defaults
module line_pixel_rasterizer import lpr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t      cfg;
    pixel_t    pix;
    out_item_t res;
    logic      accept, load, step;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign load    = accept && (s_data.mode == MODE_LOAD);
    assign step    = accept && (s_data.mode == MODE_STEP) && pix.active;

    lpr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lpr_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .step    (step),
        .item    (s_data),
        .pix     (pix)
    );

    lpr_addr u_addr (
        .pix (pix),
        .cfg (cfg),
        .res (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (step) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/lpr_cfg.sv =====
module lpr_cfg import lpr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_min_x <= CLIP_MIN_X_RST;
            cfg_reg.clip_max_x <= CLIP_MAX_X_RST;
            cfg_reg.clip_min_y <= CLIP_MIN_Y_RST;
            cfg_reg.clip_max_y <= CLIP_MAX_Y_RST;
            cfg_reg.row_bytes  <= ROW_BYTES_RST;
            cfg_reg.interleave <= IL_LINEAR;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_CLIP_MIN_X: cfg_reg.clip_min_x <= cfg_wdata[CLIP_BITS-1:0];
                REG_CLIP_MAX_X: cfg_reg.clip_max_x <= cfg_wdata[CLIP_BITS-1:0];
                REG_CLIP_MIN_Y: cfg_reg.clip_min_y <= cfg_wdata[CLIP_BITS-1:0];
                REG_CLIP_MAX_Y: cfg_reg.clip_max_y <= cfg_wdata[CLIP_BITS-1:0];
                REG_ROW_BYTES:  cfg_reg.row_bytes  <= cfg_wdata[ROWB_BITS-1:0];
                REG_INTERLEAVE: cfg_reg.interleave <= interleave_t'(cfg_wdata[IL_BITS-1:0]);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lpr_walker.sv =====
module lpr_walker import lpr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  logic     step,
    input  in_item_t item,
    output pixel_t   pix
);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [ERR_BITS-1:0]   err_x_reg, err_x_next;
    logic signed [ERR_BITS-1:0]   err_y_reg, err_y_next;
    logic [COORD_BITS-1:0]        abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0]        abs_dy_reg, abs_dy_next;
    logic [COORD_BITS-1:0]        step_count_reg, step_count_next;
    logic [STEPS_BITS-1:0]        steps_left_reg, steps_left_next;
    logic                         neg_x_reg, neg_x_next, nz_x_reg, nz_x_next;
    logic                         neg_y_reg, neg_y_next, nz_y_reg, nz_y_next;
    op_t                          line_op_reg, line_op_next;
    logic                         active_reg, active_next;

    logic signed [DELTA_BITS-1:0]   dx, dy;
    logic [COORD_BITS-1:0]          adx, ady;
    logic signed [ERR_SUM_BITS-1:0] sum_x, sum_y, sc_ext;
    logic                           move_x, move_y;

    always_comb begin
        // setup: deltas run from end point back to start point
        dx  = DELTA_BITS'(item.start_x) - DELTA_BITS'(item.end_x);
        dy  = DELTA_BITS'(item.start_y) - DELTA_BITS'(item.end_y);
        adx = dx[DELTA_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady = dy[DELTA_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

        // error walk
        sc_ext = ERR_SUM_BITS'($signed({1'b0, step_count_reg}));
        sum_x  = ERR_SUM_BITS'(err_x_reg) + ERR_SUM_BITS'($signed({1'b0, abs_dx_reg}));
        sum_y  = ERR_SUM_BITS'(err_y_reg) + ERR_SUM_BITS'($signed({1'b0, abs_dy_reg}));
        move_x = (sum_x <<< 1) > sc_ext;
        move_y = (sum_y <<< 1) > sc_ext;

        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_x_next      = err_x_reg;
        err_y_next      = err_y_reg;
        abs_dx_next     = abs_dx_reg;
        abs_dy_next     = abs_dy_reg;
        step_count_next = step_count_reg;
        steps_left_next = steps_left_reg;
        neg_x_next      = neg_x_reg;
        nz_x_next       = nz_x_reg;
        neg_y_next      = neg_y_reg;
        nz_y_next       = nz_y_reg;
        line_op_next    = line_op_reg;
        active_next     = active_reg;

        if (load) begin
            cur_x_next      = item.end_x;
            cur_y_next      = item.end_y;
            err_x_next      = '0;
            err_y_next      = '0;
            abs_dx_next     = adx;
            abs_dy_next     = ady;
            step_count_next = (adx > ady) ? adx : ady;
            steps_left_next = STEPS_BITS'((adx > ady) ? adx : ady) + STEPS_BITS'(1);
            neg_x_next      = dx[DELTA_BITS-1];
            nz_x_next       = (dx != '0);
            neg_y_next      = dy[DELTA_BITS-1];
            nz_y_next       = (dy != '0);
            // op three behaves as xor
            line_op_next    = item.draw_op[1] ? OP_XOR : op_t'(item.draw_op);
            active_next     = 1'b1;
        end else if (step) begin
            err_x_next = move_x ? ERR_BITS'(sum_x - sc_ext) : ERR_BITS'(sum_x);
            err_y_next = move_y ? ERR_BITS'(sum_y - sc_ext) : ERR_BITS'(sum_y);
            if (move_x && nz_x_reg) begin
                cur_x_next = neg_x_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
            end
            if (move_y && nz_y_reg) begin
                cur_y_next = neg_y_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
            end
            steps_left_next = steps_left_reg - STEPS_BITS'(1);
            active_next     = (steps_left_reg != STEPS_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            err_x_reg      <= '0;
            err_y_reg      <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            step_count_reg <= '0;
            steps_left_reg <= '0;
            neg_x_reg      <= 1'b0;
            nz_x_reg       <= 1'b0;
            neg_y_reg      <= 1'b0;
            nz_y_reg       <= 1'b0;
            line_op_reg    <= OP_CLEAR;
            active_reg     <= 1'b0;
        end else begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            err_x_reg      <= err_x_next;
            err_y_reg      <= err_y_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            step_count_reg <= step_count_next;
            steps_left_reg <= steps_left_next;
            neg_x_reg      <= neg_x_next;
            nz_x_reg       <= nz_x_next;
            neg_y_reg      <= neg_y_next;
            nz_y_reg       <= nz_y_next;
            line_op_reg    <= line_op_next;
            active_reg     <= active_next;
        end
    end

    assign pix.active = active_reg;
    assign pix.last   = (steps_left_reg == STEPS_BITS'(1));
    assign pix.x      = cur_x_reg;
    assign pix.y      = cur_y_reg;
    assign pix.op     = line_op_reg;

endmodule

// ===== src/lpr_addr.sv =====
module lpr_addr import lpr_pkg::*; (
    input  pixel_t    pix,
    input  cfg_t      cfg,
    output out_item_t res
);

    logic signed [CMP_BITS-1:0] x_cmp, y_cmp;
    logic signed [CMP_BITS-1:0] min_x, max_x, min_y, max_y;
    logic                       in_clip;
    logic [OFFS_BITS-1:0]       x16, y16, grp, bank, offset;

    always_comb begin
        x_cmp = CMP_BITS'(pix.x);
        y_cmp = CMP_BITS'(pix.y);
        min_x = $signed({{(CMP_BITS-CLIP_BITS){1'b0}}, cfg.clip_min_x});
        max_x = $signed({{(CMP_BITS-CLIP_BITS){1'b0}}, cfg.clip_max_x});
        min_y = $signed({{(CMP_BITS-CLIP_BITS){1'b0}}, cfg.clip_min_y});
        max_y = $signed({{(CMP_BITS-CLIP_BITS){1'b0}}, cfg.clip_max_y});
        in_clip = (x_cmp > min_x) && (x_cmp < max_x) && (y_cmp > min_y) && (y_cmp < max_y);

        x16 = OFFS_BITS'(pix.x);
        y16 = OFFS_BITS'(pix.y);

        case (cfg.interleave)
            IL_FOUR_WAY: begin
                grp  = x16 >> 2;
                bank = OFFS_BITS'(x16[1:0]) << BANK_SHIFT;
            end
            IL_LINEAR: begin
                grp  = x16;
                bank = '0;
            end
            // two-way banks, also for the unused code
            default: begin
                grp  = x16 >> 1;
                bank = OFFS_BITS'(x16[0]) << BANK_SHIFT;
            end
        endcase

        offset = bank + OFFS_BITS'(OFFS_BITS'(cfg.row_bytes) * grp) + (y16 >> COL_SHIFT);

        res.write_valid = in_clip;
        res.byte_offset = in_clip ? offset : '0;
        res.bit_mask    = in_clip ? (MASK_TOP >> y16[COL_SHIFT-1:0]) : '0;
        res.op_out      = pix.op;
        res.last        = pix.last;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lpr_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_LINES = 80;
    localparam logic [1:0] OP_XOR_ALIAS = 2'd3;
    localparam logic [1:0] IL_TWO_WAY_ALIAS = 2'd3;
    localparam logic signed [COORD_BITS-1:0] COORD_LO = 12'sh800;
    localparam logic signed [COORD_BITS-1:0] COORD_HI = 12'sh7FF;
    localparam in_item_t STEP_JUNK = '{MODE_STEP, -12'sd1, -12'sd1, -12'sd1, -12'sd1,
                                       OP_XOR_ALIAS};
    localparam out_item_t NO_PIX = '0;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t pix;
    } dir_row_t;

    localparam int NUM_DIR = 25;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // register mirror
    int win_min_x = int'(CLIP_MIN_X_RST);
    int win_max_x = int'(CLIP_MAX_X_RST);
    int win_min_y = int'(CLIP_MIN_Y_RST);
    int win_max_y = int'(CLIP_MAX_Y_RST);
    int row_pitch = int'(ROW_BYTES_RST);
    int bank_mode = int'(IL_LINEAR);

    // walker state
    int pos_x = 0, pos_y = 0, acc_x = 0, acc_y = 0, step_x = 0, step_y = 0;
    int span_x = 0, span_y = 0, walk_len = 0, pix_left = 0;
    op_t walk_op = OP_CLEAR;
    bit walking = 1'b0;

    out_item_t pending_pixels[$];
    int fail_cnt = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    dir_row_t dir_tab [NUM_DIR] = '{
        '{'{MODE_LOAD, 12'sd10, 12'sd16, 12'sd10, 12'sd16, OP_SET}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b1, '{1'b1, 16'd1002, 8'h80, OP_SET, 1'b1}},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{'{MODE_LOAD, 12'sd0, 12'sd0, 12'sd0, 12'sd0, OP_CLEAR}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b1, '{1'b0, 16'd0, 8'h00, OP_CLEAR, 1'b1}},
        '{'{MODE_LOAD, COORD_LO, COORD_HI, COORD_LO, COORD_HI, OP_XOR_ALIAS}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b1, '{1'b0, 16'd0, 8'h00, OP_XOR, 1'b1}},
        '{'{MODE_LOAD, 12'sd598, 12'sd798, 12'sd598, 12'sd798, OP_XOR}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b1, '{1'b1, 16'd59899, 8'h02, OP_XOR, 1'b1}},
        '{'{MODE_LOAD, COORD_HI, COORD_LO, COORD_LO, COORD_HI, OP_SET}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b1, '{1'b0, 16'd0, 8'h00, OP_SET, 1'b0}},
        '{STEP_JUNK, 1'b0, NO_PIX},
        // replaces the long line while it is still running
        '{'{MODE_LOAD, 12'sd8, 12'sd3, 12'sd2, 12'sd7, OP_CLEAR}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{'{MODE_LOAD, 12'sd100, 12'sd200, 12'sd103, 12'sd201, OP_XOR}, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX},
        '{STEP_JUNK, 1'b0, NO_PIX}
    };

    line_pixel_rasterizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic trace_pixel(input in_item_t it, output bit taken);
        int dx, dy, ux, uy, offs;
        out_item_t px;
        taken = 1'b1;
        if (it.mode == MODE_LOAD) begin
            dx = $signed(it.start_x) - $signed(it.end_x);
            dy = $signed(it.start_y) - $signed(it.end_y);
            step_x = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
            step_y = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
            span_x = dx < 0 ? -dx : dx;
            span_y = dy < 0 ? -dy : dy;
            walk_len = span_x > span_y ? span_x : span_y;
            pix_left = walk_len + 1;
            pos_x = $signed(it.end_x);
            pos_y = $signed(it.end_y);
            acc_x = 0;
            acc_y = 0;
            walk_op = (it.draw_op == OP_XOR_ALIAS) ? OP_XOR : op_t'(it.draw_op);
            walking = 1'b1;
        end else if (!walking) begin
            taken = 1'b0;
        end else begin
            px = '0;
            px.write_valid = pos_x > win_min_x && pos_x < win_max_x &&
                             pos_y > win_min_y && pos_y < win_max_y;
            if (px.write_valid) begin
                ux = pos_x;
                uy = pos_y;
                case (bank_mode)
                    IL_FOUR_WAY: offs = BANK_STRIDE * (ux % 4) + row_pitch * (ux / 4);
                    IL_LINEAR:   offs = ux * row_pitch;
                    default:     offs = BANK_STRIDE * (ux % 2) + row_pitch * (ux / 2);
                endcase
                px.byte_offset = OFFS_BITS'(offs + (uy >> COL_SHIFT));
                px.bit_mask = MASK_TOP >> (uy % (1 << COL_SHIFT));
            end
            px.op_out = walk_op;
            px.last = (pix_left == 1);
            pending_pixels.push_back(px);
            acc_x += span_x;
            acc_y += span_y;
            if (2 * acc_x > walk_len) begin
                acc_x -= walk_len;
                pos_x += step_x;
            end
            if (2 * acc_y > walk_len) begin
                acc_y -= walk_len;
                pos_y += step_y;
            end
            pix_left--;
            if (pix_left == 0)
                walking = 1'b0;
        end
    endtask

    task automatic send_item(input in_item_t it, output bit taken);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        trace_pixel(it, taken);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input int mnx, input int mxx, input int mny, input int mxy,
                                input int rb, input int il);
        int vals[6];
        int wr;
        reg_idx_t idx;
        vals = '{mnx, mxx, mny, mxy, rb, il};
        idx = REG_CLIP_MIN_X;
        foreach (vals[i]) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[i][CFG_DATA_BITS-1:0];
            @(posedge aclk);
            wr = vals[i] & ((1 << CFG_DATA_BITS) - 1);
            case (idx)
                REG_CLIP_MIN_X: win_min_x = wr & ((1 << CLIP_BITS) - 1);
                REG_CLIP_MAX_X: win_max_x = wr & ((1 << CLIP_BITS) - 1);
                REG_CLIP_MIN_Y: win_min_y = wr & ((1 << CLIP_BITS) - 1);
                REG_CLIP_MAX_Y: win_max_y = wr & ((1 << CLIP_BITS) - 1);
                REG_ROW_BYTES:  row_pitch = wr & ((1 << ROWB_BITS) - 1);
                REG_INTERLEAVE: bank_mode = wr & ((1 << IL_BITS) - 1);
                default: ;
            endcase
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    // keeps an endpoint offset inside the coordinate range
    function automatic int near(input int c, input int d);
        int v;
        v = c + d;
        return (v > int'(COORD_HI) || v < int'(COORD_LO)) ? c - d : v;
    endfunction

    task automatic run_lines(input int quota);
        int done_cnt, r, ex, ey, spread, hi_x, hi_y, n;
        in_item_t it;
        bit taken;
        done_cnt = 0;
        while (done_cnt < quota) begin
            r = $urandom_range(0, 99);
            it = in_item_t'({$urandom, $urandom});
            if (r < 75) begin
                // short line around the clip window, walked to its end, stepped past it or cut short
                hi_x = win_max_x + 8 > 2051 ? 2051 : win_max_x + 8;
                hi_y = win_max_y + 8 > 2051 ? 2051 : win_max_y + 8;
                ex = int'($urandom_range(0, hi_x)) - 4;
                ey = int'($urandom_range(0, hi_y)) - 4;
                spread = ($urandom_range(0, 9) == 0) ? 60 : 10;
                it.mode = MODE_LOAD;
                it.end_x = COORD_BITS'(ex);
                it.end_y = COORD_BITS'(ey);
                it.start_x = COORD_BITS'(near(ex, int'($urandom_range(0, 2 * spread)) - spread));
                it.start_y = COORD_BITS'(near(ey, int'($urandom_range(0, 2 * spread)) - spread));
                send_item(it, taken);
                done_cnt += taken;
                n = pix_left;
                if ($urandom_range(0, 7) == 0)
                    n += $urandom_range(1, 2);
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(0, pix_left);
                repeat (n) begin
                    it = in_item_t'({$urandom, $urandom});
                    it.mode = MODE_STEP;
                    send_item(it, taken);
                    done_cnt += taken;
                end
            end else if (r < 88) begin
                // full-range endpoints, usually abandoned early
                it.mode = MODE_LOAD;
                send_item(it, taken);
                done_cnt += taken;
                repeat ($urandom_range(0, 5)) begin
                    it = in_item_t'({$urandom, $urandom});
                    it.mode = MODE_STEP;
                    send_item(it, taken);
                    done_cnt += taken;
                end
            end else begin
                send_item(it, taken);
                done_cnt += taken;
            end
        end
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : pixel_check
        out_item_t want;
        bit bad;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel transaction with nothing expected: %h", m_data);
                fail_cnt++;
            end else begin
                want = pending_pixels.pop_front();
                bad = 1'b0;
                if (m_data.write_valid !== want.write_valid) begin
                    $error("write_valid: expected %0d, got %0d",
                           want.write_valid, m_data.write_valid);
                    bad = 1'b1;
                end
                if (m_data.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, m_data.byte_offset);
                    bad = 1'b1;
                end
                if (m_data.bit_mask !== want.bit_mask) begin
                    $error("bit_mask: expected %h, got %h", want.bit_mask, m_data.bit_mask);
                    bad = 1'b1;
                end
                if (m_data.op_out !== want.op_out) begin
                    $error("op_out: expected %0d, got %0d", want.op_out, m_data.op_out);
                    bad = 1'b1;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    bad = 1'b1;
                end
                if (bad)
                    fail_cnt++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        bit taken;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 30;
        rx_idle_pct = 66;
        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].item, taken);
            if (dir_tab[i].typed && pending_pixels.size() != 0)
                pending_pixels[pending_pixels.size() - 1] = dir_tab[i].pix;
        end

        for (int p = 0; p < 8; p++) begin
            drain();
            tx_idle_pct = (p < 2) ? 30 : (p < 4) ? 66 : 0;
            rx_idle_pct = (p < 2) ? 66 : (p < 4) ? 30 : 0;
            case (p)
                1: program_regs(0, 2047, 0, 2047, 255, IL_FOUR_WAY);
                2: program_regs(100, 140, 50, 120, 0, IL_TWO_WAY);
                3: program_regs(0, 2047, 0, 2047, ($urandom << ROWB_BITS) | 80,
                                ($urandom << IL_BITS) | IL_TWO_WAY_ALIAS);
                4, 6: program_regs($urandom_range(0, 200), $urandom_range(300, 2047),
                                   $urandom_range(0, 200), $urandom_range(300, 2047),
                                   $urandom_range(0, 2047), $urandom_range(0, 2047));
                5: program_regs(0, 0, 0, 0, 255, IL_LINEAR);
                7: program_regs(2047, 2047, 2047, 2047, 0, IL_FOUR_WAY);
                default: ;
            endcase
            // fill the output side while the receiver holds off
            if (p == 4)
                hold_req = 1'b1;
            run_lines(PHASE_LINES);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== line_pixel_rasterizer.f =====
src/lpr_pkg.sv
src/lpr_cfg.sv
src/lpr_walker.sv
src/lpr_addr.sv
src/line_pixel_rasterizer.sv
tb/tb_top.sv
